FILE: sv/ctl_pkg.sv
// Package: shared constants, types and sequencer states of the cache tag lookup block.
`default_nettype none
package ctl_pkg;
   localparam int LINES     = 8;
   localparam int LINE_BITS = 3;
   localparam int TAG_W     = 27;
   localparam int AGE_W     = 3;
   localparam int ENTRY_W   = 1 + AGE_W + TAG_W;
   localparam int WORDS_PER_BLOCK = 8;

   localparam logic [2:0] REG_WAYS      = 3'd0;
   localparam logic [2:0] REG_USE_LRU   = 3'd1;
   localparam logic [2:0] REG_WORD8     = 3'd2;
   localparam logic [2:0] REG_CACHE_T   = 3'd3;
   localparam logic [2:0] REG_MEMORY_T  = 3'd4;
   localparam logic [2:0] REG_BUFFER_T  = 3'd5;

   typedef struct packed {
      logic              dirty;
      logic [AGE_W-1:0]  age;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;
endpackage
`default_nettype wire

FILE: sv/cache_tag_lookup_fifo_lru.sv
// Top level: set-associative cache tag controller with FIFO or LRU replacement.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | address, op
//  rsp     | out       | rsp_valid/stall   | is_hit, wrote_back, line_used, access_cycles, totals
//  csr     | in        | psel/penable/...  | six registers at byte addresses 0..20
//
// An item runs through a scan pass (one read of the line store per way, one
// more for the last read data), an update pass that reads, modifies and writes
// back each way, then a load of the result register. The next item is taken
// only once the block is back in idle, so items do not overlap.
// Reset clears valid bits, counters and registers; the line store needs no clear
// as a line that is not valid reads as zero. A stalled result holds; the next
// item is taken once the result register is loaded.
`default_nettype none
module cache_tag_lookup_fifo_lru
   import ctl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_address,
   input  wire logic        req_op,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_is_hit,
   output logic             rsp_wrote_back,
   output logic [2:0]       rsp_line_used,
   output logic [11:0]      rsp_access_cycles,
   output logic [31:0]      rsp_hit_total,
   output logic [31:0]      rsp_miss_total,
   output logic [31:0]      rsp_time_total,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   // configuration registers
   logic [3:0] ways_ff;
   logic       use_lru_ff, word8_ff;
   logic [7:0] cache_t_ff, memory_t_ff, buffer_t_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff     <= 4'd1;
         use_lru_ff  <= 1'b0;
         word8_ff    <= 1'b0;
         cache_t_ff  <= 8'd2;
         memory_t_ff <= 8'd21;
         buffer_t_ff <= 8'd1;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_WAYS:     ways_ff     <= pwdata[3:0];
            REG_USE_LRU:  use_lru_ff  <= pwdata[0];
            REG_WORD8:    word8_ff    <= pwdata[0];
            REG_CACHE_T:  cache_t_ff  <= pwdata[7:0];
            REG_MEMORY_T: memory_t_ff <= pwdata[7:0];
            REG_BUFFER_T: buffer_t_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_WAYS:     prdata = {28'd0, ways_ff};
         REG_USE_LRU:  prdata = {31'd0, use_lru_ff};
         REG_WORD8:    prdata = {31'd0, word8_ff};
         REG_CACHE_T:  prdata = {24'd0, cache_t_ff};
         REG_MEMORY_T: prdata = {24'd0, memory_t_ff};
         REG_BUFFER_T: prdata = {24'd0, buffer_t_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // item context
   state_type state_ff, state_in;
   logic [1:0]       wlg_ff;        // log2 of effective ways
   logic [3:0]       w_ff;          // effective ways
   logic [2:0]       set_ff;
   logic [TAG_W-1:0] tag_ff;
   logic             op_ff;
   logic [3:0]       cnt_ff;
   logic             rd_pend_ff;
   logic [2:0]       rd_line_ff;
   logic [LINES-1:0] valid_ff;

   // scan results
   logic hit_ff, empty_ff, have_vic_ff, vic_dirty_ff;
   logic [2:0] hit_line_ff, empty_line_ff, vic_line_ff, hit_age_ff, max_age_ff;

   // counters
   logic [31:0] hit_cnt_ff, miss_cnt_ff, cyc_cnt_ff;
   logic        rsp_valid_ff;

   // decode of the incoming address
   logic [1:0]  wlg_new;
   logic [3:0]  w_new;
   logic [26:0] block_new;
   logic [1:0]  lg_new;
   always_comb begin
      case (ways_ff)
         4'd2:    begin wlg_new = 2'd1; w_new = 4'd2; end
         4'd4:    begin wlg_new = 2'd2; w_new = 4'd4; end
         4'd8:    begin wlg_new = 2'd3; w_new = 4'd8; end
         default: begin wlg_new = 2'd0; w_new = 4'd1; end
      endcase
      lg_new    = 2'd3 - wlg_new;
      block_new = word8_ff ? {1'b0, req_address[31:6]} : req_address[31:5];
   end

   wire logic accept  = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);

   logic [1:0] lg;
   logic [2:0] age_mask, issue_line;
   logic       issue;
   assign lg         = 2'd3 - wlg_ff;
   assign age_mask   = 3'(w_ff - 4'd1);
   assign issue_line = 3'(cnt_ff[2:0] << lg) | set_ff;
   assign issue      = (state_ff == ST_SCAN || state_ff == ST_UPDATE) && (cnt_ff < w_ff);

   entry_type rd_data, rd_entry, wr_entry;
   logic      rd_v, wr_en;
   ctl_line_ram u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (rd_line_ff),
      .wdata (wr_entry),
      .raddr (issue_line),
      .rdata (rd_data)
   );

   assign rd_v     = valid_ff[rd_line_ff];
   assign rd_entry = rd_v ? rd_data : '0;

   // outcome of the scan
   logic       wb;
   logic [2:0] fill_line;
   assign fill_line = hit_ff ? hit_line_ff : (empty_ff ? empty_line_ff : vic_line_ff);
   assign wb        = !hit_ff && !empty_ff && vic_dirty_ff;

   // modify stage of the update pass
   always_comb begin
      wr_entry = rd_entry;
      wr_en    = 1'b0;
      if (state_ff == ST_UPDATE && rd_pend_ff) begin
         wr_en = 1'b1;
         if (hit_ff) begin
            if (rd_line_ff == hit_line_ff) begin
               if (op_ff) wr_entry.dirty = 1'b1;
               if (use_lru_ff) wr_entry.age = '0;
            end else if (use_lru_ff && rd_v && rd_entry.age < hit_age_ff) begin
               wr_entry.age = (rd_entry.age + 3'd1) & age_mask;
            end
         end else if (rd_line_ff == fill_line) begin
            wr_entry.dirty = 1'b0;
            wr_entry.age   = '0;
            wr_entry.tag   = tag_ff;
         end else if (rd_v) begin
            wr_entry.age = (rd_entry.age + 3'd1) & age_mask;
         end
      end
   end

   // cost of this item
   logic [10:0] transfer;
   logic [12:0] cost;
   assign transfer = 11'(memory_t_ff) + 11'(buffer_t_ff) * 11'(WORDS_PER_BLOCK - 1);
   assign cost     = hit_ff ? 13'(cache_t_ff)
                   : 13'(cache_t_ff) + (wb ? {1'b0, transfer, 1'b0} : 13'(transfer));

   logic [32:0] hit_sum, miss_sum, cyc_sum;
   assign hit_sum  = 33'(hit_cnt_ff) + 33'(hit_ff);
   assign miss_sum = 33'(miss_cnt_ff) + 33'(!hit_ff);
   assign cyc_sum  = 33'(cyc_cnt_ff) + 33'(cost);

   wire logic load_rsp = (state_ff == ST_FINISH) && !(rsp_valid_ff && rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SCAN;
         ST_SCAN:   if (!issue) state_in = ST_UPDATE;
         ST_UPDATE: if (!issue) state_in = ST_FINISH;
         ST_FINISH: if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         cyc_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
         rd_line_ff <= issue_line;
         if (accept) begin
            wlg_ff       <= wlg_new;
            w_ff         <= w_new;
            set_ff       <= block_new[2:0] & (3'b111 >> wlg_new);
            tag_ff       <= block_new >> lg_new;
            op_ff        <= req_op;
            cnt_ff       <= '0;
            hit_ff       <= 1'b0;
            empty_ff     <= 1'b0;
            have_vic_ff  <= 1'b0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + 4'd1;
         end else if (state_ff == ST_SCAN) begin
            cnt_ff <= '0;      // restart the way count for the update pass
         end
         // evaluate one way per cycle of the scan
         if (state_ff == ST_SCAN && rd_pend_ff) begin
            if (rd_v) begin
               if (!hit_ff && rd_entry.tag == tag_ff) begin
                  hit_ff      <= 1'b1;
                  hit_line_ff <= rd_line_ff;
                  hit_age_ff  <= rd_entry.age;
               end
               if (!have_vic_ff || rd_entry.age > max_age_ff) begin
                  have_vic_ff  <= 1'b1;
                  max_age_ff   <= rd_entry.age;
                  vic_line_ff  <= rd_line_ff;
                  vic_dirty_ff <= rd_entry.dirty;
               end
            end else if (!empty_ff) begin
               empty_ff      <= 1'b1;
               empty_line_ff <= rd_line_ff;
            end
         end
         if (state_ff == ST_UPDATE && rd_pend_ff && !hit_ff && rd_line_ff == fill_line) begin
            valid_ff[rd_line_ff] <= 1'b1;
         end
         // drop the result once taken, load the next one when free
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            hit_cnt_ff   <= hit_sum[32] ? '1 : hit_sum[31:0];
            miss_cnt_ff  <= miss_sum[32] ? '1 : miss_sum[31:0];
            cyc_cnt_ff   <= cyc_sum[32] ? '1 : cyc_sum[31:0];
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_is_hit        <= hit_ff;
         rsp_wrote_back    <= wb;
         rsp_line_used     <= fill_line;
         rsp_access_cycles <= cost[12] ? 12'hFFF : cost[11:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_total  = hit_cnt_ff;
   assign rsp_miss_total = miss_cnt_ff;
   assign rsp_time_total = cyc_cnt_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= w_ff))
      else $error("way count beyond associativity");
   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !rd_pend_ff && !wr_en)
      else $error("line store access while finishing");
   a_wb_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wrote_back) |-> !rsp_is_hit)
      else $error("writeback on a hit");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_hit_total))
      else $error("stalled result changed");
endmodule
`default_nettype wire

FILE: sv/ctl_line_ram.sv
// Line store: one write port, one registered read port.
`default_nettype none
module ctl_line_ram
   import ctl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [LINE_BITS-1:0] waddr,
   input  wire entry_type            wdata,
   input  wire logic [LINE_BITS-1:0] raddr,
   output entry_type                 rdata
);
   entry_type mem [LINES];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire
